FILE: rtl/core/alst_pkg.sv
// Package for the adaptive launch speed target block.
// Types, register codes and constants shared by all rtl/core files; no dependencies.
package alst_pkg;

  localparam int unsigned SPEED_W = 14;
  localparam int unsigned WHEEL_W = 16;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ARITH_W = 22;

  localparam logic [TIME_W-1:0] HOLD_MS = 32'd300;
  localparam logic [TIME_W-1:0] REPEAT_MS = 32'd500;

  localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST = 14'd2500;
  localparam logic [SPEED_W-1:0] SPEED_GOAL_RST = 14'd2480;
  localparam logic [SPEED_W-1:0] VALID_MIN_RST = 14'd500;
  localparam logic [SPEED_W-1:0] VALID_MAX_RST = 14'd3500;
  localparam logic [WHEEL_W-1:0] WHEEL_MIN_RST = 16'd30000;
  localparam logic [WHEEL_W-1:0] WHEEL_MAX_RST = 16'd36500;
  localparam logic [WHEEL_W-1:0] DOWN_STEP_RST = 16'd1500;
  localparam logic [WHEEL_W-1:0] UP_STEP_RST = 16'd250;
  localparam logic [WHEEL_W-1:0] TARGET_RST = 16'd35500;

  typedef enum logic [2:0] {
    REG_SPEED_LIMIT = 3'd0,
    REG_SPEED_GOAL  = 3'd1,
    REG_VALID_MIN   = 3'd2,
    REG_VALID_MAX   = 3'd3,
    REG_WHEEL_MIN   = 3'd4,
    REG_WHEEL_MAX   = 3'd5,
    REG_DOWN_STEP   = 3'd6,
    REG_UP_STEP     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_limit;
    logic [SPEED_W-1:0] speed_goal;
    logic [SPEED_W-1:0] valid_min;
    logic [SPEED_W-1:0] valid_max;
    logic [WHEEL_W-1:0] wheel_min;
    logic [WHEEL_W-1:0] wheel_max;
    logic [WHEEL_W-1:0] down_step;
    logic [WHEEL_W-1:0] up_step;
  } cfg_t;

  typedef struct packed {
    logic [WHEEL_W-1:0]  target;
    logic [SAMPLE_W-1:0] last_sample;
    logic [TIME_W-1:0]   last_time;
    logic [TIME_W-1:0]   hold_until;
    logic                hold_armed;
  } state_t;

  typedef struct packed {
    logic [WHEEL_W-1:0] wheel_target;
    logic               feed_hold;
    logic               target_updated;
  } result_t;

endpackage

FILE: rtl/core/alst_regs.sv
// Configuration register file with an APB-style access port.
// Depends on alst_pkg for the register codes, reset values and cfg_t.
module alst_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [alst_pkg::ADDR_W-1:0] paddr,
  input  logic [alst_pkg::DATA_W-1:0] pwdata,
  output logic [alst_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output alst_pkg::cfg_t              cfg_o
);
  import alst_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_limit <= SPEED_LIMIT_RST;
      cfg_q.speed_goal  <= SPEED_GOAL_RST;
      cfg_q.valid_min   <= VALID_MIN_RST;
      cfg_q.valid_max   <= VALID_MAX_RST;
      cfg_q.wheel_min   <= WHEEL_MIN_RST;
      cfg_q.wheel_max   <= WHEEL_MAX_RST;
      cfg_q.down_step   <= DOWN_STEP_RST;
      cfg_q.up_step     <= UP_STEP_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SPEED_LIMIT: cfg_q.speed_limit <= pwdata[SPEED_W-1:0];
        REG_SPEED_GOAL:  cfg_q.speed_goal  <= pwdata[SPEED_W-1:0];
        REG_VALID_MIN:   cfg_q.valid_min   <= pwdata[SPEED_W-1:0];
        REG_VALID_MAX:   cfg_q.valid_max   <= pwdata[SPEED_W-1:0];
        REG_WHEEL_MIN:   cfg_q.wheel_min   <= pwdata[WHEEL_W-1:0];
        REG_WHEEL_MAX:   cfg_q.wheel_max   <= pwdata[WHEEL_W-1:0];
        REG_DOWN_STEP:   cfg_q.down_step   <= pwdata[WHEEL_W-1:0];
        REG_UP_STEP:     cfg_q.up_step     <= pwdata[WHEEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_SPEED_LIMIT: prdata = {{(DATA_W-SPEED_W){1'b0}}, cfg_q.speed_limit};
      REG_SPEED_GOAL:  prdata = {{(DATA_W-SPEED_W){1'b0}}, cfg_q.speed_goal};
      REG_VALID_MIN:   prdata = {{(DATA_W-SPEED_W){1'b0}}, cfg_q.valid_min};
      REG_VALID_MAX:   prdata = {{(DATA_W-SPEED_W){1'b0}}, cfg_q.valid_max};
      REG_WHEEL_MIN:   prdata = {{(DATA_W-WHEEL_W){1'b0}}, cfg_q.wheel_min};
      REG_WHEEL_MAX:   prdata = {{(DATA_W-WHEEL_W){1'b0}}, cfg_q.wheel_max};
      REG_DOWN_STEP:   prdata = {{(DATA_W-WHEEL_W){1'b0}}, cfg_q.down_step};
      REG_UP_STEP:     prdata = {{(DATA_W-WHEEL_W){1'b0}}, cfg_q.up_step};
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/alst_update.sv
// Single-pass update logic: sample gating, step, clamps and feed-hold timing.
// Depends on alst_pkg for cfg_t, state_t, result_t and the time constants.
module alst_update (
  input  alst_pkg::cfg_t                cfg_i,
  input  alst_pkg::state_t              state_i,
  input  logic [alst_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [alst_pkg::TIME_W-1:0]   time_i,
  output alst_pkg::state_t              state_o,
  output alst_pkg::result_t             result_o
);
  import alst_pkg::*;

  logic                      in_range, at_limit, near, recent, accept;
  logic [SAMPLE_W-1:0]       sample_diff;
  logic [TIME_W-1:0]         elapsed, hold_left;
  logic signed [ARITH_W-1:0] goal_err, prod, half, step_lo, step_hi, step, sum;
  logic signed [ARITH_W-1:0] wmin, wmax, target_new;

  always_comb begin
    in_range = (sample_i >= {{(SAMPLE_W-SPEED_W){1'b0}}, cfg_i.valid_min}) &&
               (sample_i <= {{(SAMPLE_W-SPEED_W){1'b0}}, cfg_i.valid_max});
    at_limit = sample_i >= {{(SAMPLE_W-SPEED_W){1'b0}}, cfg_i.speed_limit};

    sample_diff = (sample_i > state_i.last_sample) ? sample_i - state_i.last_sample
                                                   : state_i.last_sample - sample_i;
    near = sample_diff <= SAMPLE_W'(1);

    // Negative elapsed time (wrap) counts as recent.
    elapsed = time_i - state_i.last_time;
    recent  = elapsed[TIME_W-1] || (elapsed < REPEAT_MS);

    // Drop repeats unless they are overspeed and old enough.
    accept = in_range && !(near && (!at_limit || recent));

    goal_err = $signed({{(ARITH_W-SPEED_W){1'b0}}, cfg_i.speed_goal}) -
               $signed({{(ARITH_W-SAMPLE_W){1'b0}}, sample_i});
    prod = (goal_err <<< 3) + (goal_err <<< 1) + goal_err;
    half = prod >>> 1;

    step_lo = -$signed({{(ARITH_W-WHEEL_W){1'b0}}, cfg_i.down_step});
    step_hi = $signed({{(ARITH_W-WHEEL_W){1'b0}}, cfg_i.up_step});
    if (at_limit) begin
      step = step_lo;
    end else if (half < step_lo) begin
      step = step_lo;
    end else if (half > step_hi) begin
      step = step_hi;
    end else begin
      step = half;
    end

    sum  = $signed({{(ARITH_W-WHEEL_W){1'b0}}, state_i.target}) + step;
    wmin = $signed({{(ARITH_W-WHEEL_W){1'b0}}, cfg_i.wheel_min});
    wmax = $signed({{(ARITH_W-WHEEL_W){1'b0}}, cfg_i.wheel_max});
    if (sum < wmin) begin
      target_new = wmin;
    end else if (sum > wmax) begin
      target_new = wmax;
    end else begin
      target_new = sum;
    end

    state_o = state_i;
    if (accept) begin
      state_o.target      = target_new[WHEEL_W-1:0];
      state_o.last_sample = sample_i;
      state_o.last_time   = time_i;
      if (at_limit) begin
        state_o.hold_until = time_i + HOLD_MS;
        state_o.hold_armed = 1'b1;
      end
    end

    // Disarm once the hold is seen expired so a wrap never revives it.
    hold_left = time_i - state_o.hold_until;
    result_o.feed_hold = state_o.hold_armed && hold_left[TIME_W-1];
    state_o.hold_armed = result_o.feed_hold;

    result_o.wheel_target   = state_o.target;
    result_o.target_updated = accept;
  end

endmodule

FILE: rtl/core/adaptive_launch_speed_target.sv
// Adaptive launch speed target: top level with input and result registers.
// Pipeline: input register, then result register; the update logic sits between them.
// Throughput: one transfer per cycle unless out_stall_i holds a waiting result.
// Reset: asynchronous, active low; registers return to their reset values,
// target to 35500, hold disarmed, both pipeline registers empty. No clearing pass.
// Depends on alst_pkg, alst_regs and alst_update.
module adaptive_launch_speed_target (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [alst_pkg::SAMPLE_W-1:0] speed_sample_i,
  input  logic [alst_pkg::TIME_W-1:0]   time_ms_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [alst_pkg::WHEEL_W-1:0]  wheel_target_o,
  output logic                          feed_hold_o,
  output logic                          target_updated_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [alst_pkg::ADDR_W-1:0]   paddr,
  input  logic [alst_pkg::DATA_W-1:0]   pwdata,
  output logic [alst_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import alst_pkg::*;

  cfg_t    cfg;
  state_t  st_q, st_d;
  result_t res_d, res_q;

  logic                s1_valid_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic [TIME_W-1:0]   s1_time_q;
  logic                out_valid_q;
  logic                s2_stall, s1_adv, in_xfer;

  alst_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  alst_update u_update (
    .cfg_i    (cfg),
    .state_i  (st_q),
    .sample_i (s1_sample_q),
    .time_i   (s1_time_q),
    .state_o  (st_d),
    .result_o (res_d)
  );

  // The result register is blocked only while it holds an untaken transfer.
  assign s2_stall   = out_valid_q && out_stall_i;
  // Advance the input register into the result register whenever it can move.
  assign s1_adv     = s1_valid_q && !s2_stall;
  // The input register takes a new transfer if it is empty or draining this cycle.
  assign in_stall_o = s1_valid_q && s2_stall;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Payload holds no reset; load only on a transfer.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_sample_q <= speed_sample_i;
      s1_time_q   <= time_ms_i;
    end
  end

  // Adaptation state commits as the item moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.target      <= TARGET_RST;
      st_q.last_sample <= '0;
      st_q.last_time   <= '0;
      st_q.hold_until  <= '0;
      st_q.hold_armed  <= 1'b0;
    end else if (s1_adv) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!s2_stall) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign wheel_target_o   = res_q.wheel_target;
  assign feed_hold_o      = res_q.feed_hold;
  assign target_updated_o = res_q.target_updated;

  // An item that leaves the input register shows up as a valid result.
  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advanced item did not reach the result register");

  // A shown feed hold matches the armed state committed with it.
  a_hold_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.feed_hold |-> st_q.hold_armed)
    else $error("feed hold shown without an armed hold");

  // A taken result with nothing behind it empties the result register.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_stall_i && !s1_valid_q |=> !out_valid_q)
    else $error("result repeated after transfer");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for adaptive_launch_speed_target: drives speed samples and the
// APB register port, predicts every result in-bench and checks each result transfer.
// Depends on alst_pkg and the block's RTL only.
module tb;
  import alst_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_PRINTS = 60;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [SAMPLE_W-1:0] speed_sample_i = '0;
  logic [TIME_W-1:0]   time_ms_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [WHEEL_W-1:0]  wheel_target_o;
  logic                feed_hold_o;
  logic                target_updated_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  adaptive_launch_speed_target u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .speed_sample_i  (speed_sample_i),
    .time_ms_i       (time_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .wheel_target_o  (wheel_target_o),
    .feed_hold_o     (feed_hold_o),
    .target_updated_o(target_updated_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Shadow of the block: register copy plus adaptation state.
  cfg_t               est_cfg;
  logic [WHEEL_W-1:0] est_target;
  logic [SAMPLE_W-1:0] est_last_sample;
  logic [TIME_W-1:0]  est_last_time;
  logic [TIME_W-1:0]  est_hold_until;
  logic               est_hold_armed;

  result_t pending_targets[$];
  int      error_count = 0;
  int      cycle_count = 0;
  int      gap_pct = 0;
  int      stall_pct = 0;
  int      holdoff_left = 0;
  logic [TIME_W-1:0] now_ms;

  // 10 ns clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_error(string msg);
    if (error_count < MAX_PRINTS) $display("%0t: %s", $time, msg);
    error_count++;
  endtask

  // Work out the result of one sample transfer and advance the shadow state.
  function automatic result_t compute_wheel_target(logic [SAMPLE_W-1:0] spd,
                                                    logic [TIME_W-1:0] now);
    result_t           r;
    logic              take;
    logic [SAMPLE_W-1:0] diff;
    logic [TIME_W-1:0] elapsed;
    longint            step;
    longint            sum;
    take = (spd >= est_cfg.valid_min) && (spd <= est_cfg.valid_max);
    if (take) begin
      diff = (spd > est_last_sample) ? spd - est_last_sample : est_last_sample - spd;
      if (diff <= 1) begin
        // Near-repeat: only an overspeed that is not recent gets through.
        elapsed = now - est_last_time;
        if (spd < est_cfg.speed_limit || elapsed[TIME_W-1] || elapsed < REPEAT_MS)
          take = 1'b0;
      end
    end
    if (take) begin
      step = (longint'(est_cfg.speed_goal) - longint'(spd)) * 11;
      step = step >>> 1;  // floor toward minus infinity
      if (step < -longint'(est_cfg.down_step)) step = -longint'(est_cfg.down_step);
      else if (step > longint'(est_cfg.up_step)) step = longint'(est_cfg.up_step);
      if (spd >= est_cfg.speed_limit) begin
        step = -longint'(est_cfg.down_step);
        est_hold_until = now + HOLD_MS;
        est_hold_armed = 1'b1;
      end
      sum = longint'(est_target) + step;
      // Crossed wheel bounds: a sum under wheel_min gets wheel_min, any other sum gets wheel_max.
      if (sum < longint'(est_cfg.wheel_min)) sum = longint'(est_cfg.wheel_min);
      else if (sum > longint'(est_cfg.wheel_max)) sum = longint'(est_cfg.wheel_max);
      est_target = sum[WHEEL_W-1:0];
      est_last_sample = spd;
      est_last_time = now;
    end
    elapsed = now - est_hold_until;
    r.feed_hold = est_hold_armed && elapsed[TIME_W-1];
    // Drop the hold once seen expired so a later wrap cannot revive it.
    if (est_hold_armed && !r.feed_hold) est_hold_armed = 1'b0;
    r.wheel_target = est_target;
    r.target_updated = take;
    return r;
  endfunction

  // Predict on every accepted input transfer.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      pending_targets.push_back(compute_wheel_target(speed_sample_i, time_ms_i));
  end

  // Compare every accepted result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_targets.size() == 0) begin
        report_error($sformatf("result transfer with nothing expected, target %0d",
                               wheel_target_o));
      end else begin
        want = pending_targets.pop_front();
        if (wheel_target_o !== want.wheel_target)
          report_error($sformatf("wheel_target got %0d want %0d",
                                 wheel_target_o, want.wheel_target));
        if (feed_hold_o !== want.feed_hold)
          report_error($sformatf("feed_hold got %0b want %0b",
                                 feed_hold_o, want.feed_hold));
        if (target_updated_o !== want.target_updated)
          report_error($sformatf("target_updated got %0b want %0b",
                                 target_updated_o, want.target_updated));
      end
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (holdoff_left > 0) begin
      out_stall_i <= 1'b1;
      holdoff_left = holdoff_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic logic [DATA_W-1:0] reg_field(cfg_t c, reg_idx_e idx);
    case (idx)
      REG_SPEED_LIMIT: return DATA_W'(c.speed_limit);
      REG_SPEED_GOAL:  return DATA_W'(c.speed_goal);
      REG_VALID_MIN:   return DATA_W'(c.valid_min);
      REG_VALID_MAX:   return DATA_W'(c.valid_max);
      REG_WHEEL_MIN:   return DATA_W'(c.wheel_min);
      REG_WHEEL_MAX:   return DATA_W'(c.wheel_max);
      REG_DOWN_STEP:   return DATA_W'(c.down_step);
      default:         return DATA_W'(c.up_step);
    endcase
  endfunction

  // APB write: setup, access, then idle so the next transfer starts clean.
  task automatic write_reg(reg_idx_e idx, logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_SPEED_LIMIT: est_cfg.speed_limit = data[SPEED_W-1:0];
      REG_SPEED_GOAL:  est_cfg.speed_goal = data[SPEED_W-1:0];
      REG_VALID_MIN:   est_cfg.valid_min = data[SPEED_W-1:0];
      REG_VALID_MAX:   est_cfg.valid_max = data[SPEED_W-1:0];
      REG_WHEEL_MIN:   est_cfg.wheel_min = data[WHEEL_W-1:0];
      REG_WHEEL_MAX:   est_cfg.wheel_max = data[WHEEL_W-1:0];
      REG_DOWN_STEP:   est_cfg.down_step = data[WHEEL_W-1:0];
      default:         est_cfg.up_step = data[WHEEL_W-1:0];
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(reg_idx_e idx);
    logic [DATA_W-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_W'(idx) << 2;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    if (got !== reg_field(est_cfg, idx))
      report_error($sformatf("register %s reads %0d want %0d",
                             idx.name(), got, reg_field(est_cfg, idx)));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write all registers with junk above each field's width, then read each one back.
  task automatic write_config(cfg_t c);
    reg_idx_e          idx;
    logic [DATA_W-1:0] mask;
    for (int i = 0; i < 8; i++) begin
      idx = reg_idx_e'(i);
      mask = (idx <= REG_VALID_MAX) ? DATA_W'((1 << SPEED_W) - 1)
                                    : DATA_W'((1 << WHEEL_W) - 1);
      write_reg(idx, ($urandom & ~mask) | reg_field(c, idx));
      check_reg(idx);
    end
  endtask

  function automatic cfg_t make_cfg(int limit, int goal, int vmin, int vmax,
                                    int wmin, int wmax, int down, int up);
    cfg_t c;
    c.speed_limit = limit[SPEED_W-1:0];
    c.speed_goal = goal[SPEED_W-1:0];
    c.valid_min = vmin[SPEED_W-1:0];
    c.valid_max = vmax[SPEED_W-1:0];
    c.wheel_min = wmin[WHEEL_W-1:0];
    c.wheel_max = wmax[WHEEL_W-1:0];
    c.down_step = down[WHEEL_W-1:0];
    c.up_step = up[WHEEL_W-1:0];
    return c;
  endfunction

  // Pick zero, the field maximum, or anything between.
  function automatic int corner_value(int top);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  function automatic cfg_t random_cfg(bit wild);
    int goal;
    int limit;
    int wmin;
    if (wild)
      return make_cfg(corner_value(16383), corner_value(16383), corner_value(16383),
                      corner_value(16383), corner_value(65535), corner_value(65535),
                      corner_value(65535), corner_value(65535));
    goal = $urandom_range(1500, 3000);
    limit = goal + $urandom_range(0, 500);
    wmin = $urandom_range(20000, 32000);
    return make_cfg(limit, goal, $urandom_range(0, 1000), $urandom_range(limit, 10000),
                    wmin, wmin + $urandom_range(0, 10000), $urandom_range(0, 3000),
                    $urandom_range(0, 1000));
  endfunction

  // Offer one sample transfer after an optional gap; hold the payload until it is taken.
  task automatic send_sample(logic [SAMPLE_W-1:0] spd, logic [TIME_W-1:0] now);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    speed_sample_i <= spd;
    time_ms_i <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every predicted result has come back, plus the latency.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_targets.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Sample near the goal, clamped at zero.
  function automatic logic [SAMPLE_W-1:0] near_goal(int spread);
    int v;
    v = int'(est_cfg.speed_goal) + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic test_reset_values();
    for (int i = 0; i < 8; i++) check_reg(reg_idx_e'(i));
  endtask

  // Walk the documented corners with the reset configuration.
  task automatic test_directed_samples();
    send_sample(16'd0, 32'd100);          // below range
    send_sample(16'd65535, 32'd200);      // above range
    send_sample(16'd499, 32'd300);        // one under valid_min
    send_sample(16'd500, 32'd400);        // valid_min, step clamps to up_step
    send_sample(16'd3500, 32'd1000);      // valid_max, overspeed, arms hold
    send_sample(16'd3501, 32'd1100);      // one over valid_max, hold still on
    send_sample(16'd3500, 32'd1200);      // repeat overspeed, too recent
    send_sample(16'd2000, 32'd1300);      // hold expires exactly here
    send_sample(16'd2001, 32'd1400);      // near-repeat under the limit
    send_sample(16'd2001, 32'd5000);      // still under the limit, ignored
    send_sample(16'd2500, 32'd5100);      // exactly at the limit
    send_sample(16'd2501, 32'd5300);      // near-repeat overspeed, recent
    send_sample(16'd2501, 32'd5600);      // near-repeat overspeed, exactly REPEAT_MS later
    send_sample(16'd2479, 32'd6000);      // small positive step
    send_sample(16'd2481, 32'd6100);      // small negative step rounds down
    send_sample(16'd2480, 32'd6200);      // near-repeat, ignored
    send_sample(16'd3000, 32'hFFFF_FF00); // overspeed, hold end wraps past zero
    send_sample(16'd3001, 32'h0000_0010); // across the wrap, still recent and held
    send_sample(16'd3001, 32'h8000_0000); // negative elapsed counts as recent
    send_sample(16'd3000, 32'h0000_0200); // time went back, but not recent to the last taken sample
    send_sample(16'd3001, 32'h0000_0300); // near-repeat overspeed, recent, dropped
    for (int i = 0; i < 4; i++)
      send_sample(16'd3400 - 16'(i * 10), 32'h0000_0400 + 32'(i * 700));  // drive toward wheel_min
    drain();
  endtask

  // Crossed wheel bounds, inverted valid range, zero and full steps.
  task automatic test_config_corners();
    cfg_t corners[4];
    corners[0] = make_cfg(16383, 16383, 0, 16383, 40000, 20000, 0, 65535);
    corners[1] = make_cfg(16383, 0, 16383, 0, 40000, 20000, 65535, 65535);
    corners[2] = make_cfg(0, 0, 0, 16383, 0, 65535, 65535, 0);
    corners[3] = make_cfg(0, 0, 0, 0, 0, 0, 0, 0);
    gap_pct = 10;
    stall_pct = 10;
    now_ms = $urandom;
    foreach (corners[k]) begin
      write_config(corners[k]);
      for (int i = 0; i < 18; i++) begin
        now_ms = now_ms + $urandom_range(0, 900);
        case ($urandom_range(0, 5))
          0:       send_sample(16'd0, now_ms);
          1:       send_sample(16'hFFFF, now_ms);
          2:       send_sample(16'(corner_value(16384)), now_ms);
          3:       send_sample(est_last_sample + 16'($urandom_range(0, 1)), now_ms);
          default: send_sample(16'($urandom), now_ms);
        endcase
      end
      drain();
    end
  endtask

  // Mostly well-formed samples around the goal with near-repeats and overspeeds,
  // the rest noise and time jumps; split the items evenly over four configurations.
  task automatic test_random_traffic(int in_gap, int out_stall, int items);
    int sent;
    int pick;
    gap_pct = in_gap;
    stall_pct = out_stall;
    for (int k = 0; k < 4; k++) begin
      write_config(random_cfg(k == 3));
      now_ms = $urandom;
      sent = 0;
      while (sent < items / 4) begin
        pick = $urandom_range(0, 99);
        now_ms = now_ms + $urandom_range(0, 700);
        if (pick < 55) begin
          send_sample(near_goal(200), now_ms);
        end else if (pick < 72) begin
          now_ms = now_ms + $urandom_range(0, 600);
          send_sample(est_last_sample + 16'($urandom_range(0, 2)) - 16'd1, now_ms);
        end else if (pick < 84) begin
          send_sample(16'(est_cfg.speed_limit) + 16'($urandom_range(0, 300)), now_ms);
        end else if (pick < 93) begin
          send_sample(16'($urandom), now_ms);
        end else begin
          now_ms = $urandom;
          send_sample(near_goal(300), now_ms);
        end
        sent++;
      end
      drain();
    end
  endtask

  // Hold the receiver off for a long stretch while samples keep coming,
  // so the pipeline fills and the input stalls.
  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    write_config(random_cfg(1'b0));
    holdoff_left = 200;
    for (int i = 0; i < 60; i++) begin
      now_ms = now_ms + $urandom_range(1, 400);
      send_sample(near_goal(300), now_ms);
    end
    drain();
  endtask

  initial begin
    est_cfg = make_cfg(int'(SPEED_LIMIT_RST), int'(SPEED_GOAL_RST), int'(VALID_MIN_RST),
                       int'(VALID_MAX_RST), int'(WHEEL_MIN_RST), int'(WHEEL_MAX_RST),
                       int'(DOWN_STEP_RST), int'(UP_STEP_RST));
    est_target = TARGET_RST;
    est_last_sample = '0;
    est_last_time = '0;
    est_hold_until = '0;
    est_hold_armed = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    gap_pct = 20;
    stall_pct = 65;
    test_directed_samples();
    test_config_corners();
    test_random_traffic(20, 65, 380);
    test_random_traffic(65, 20, 380);
    test_random_traffic(0, 0, 380);
    test_backpressure();

    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
